@@ design/tts_pkg.sv @@
// Shared constants, codes and types for the timed task wakeup scheduler.
`default_nettype none
package tts_pkg;
    localparam int SLOTS = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int GUARD_W = $clog2(SLOTS + 1);
    localparam int DIV_W = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [15:0] WAKE_NEVER = 16'hFFFF;
    localparam logic [15:0] WAKE_SAT = 16'hFFFE;
    localparam logic [16:0] REBASE_LIM = 17'h07FFF;
    localparam logic [7:0] SLOT_NONE = 8'hFF;

    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_FORK = 3'd1;
    localparam logic [2:0] OP_KILL = 3'd2;
    localparam logic [2:0] OP_QUEUE = 3'd3;
    localparam logic [2:0] OP_HIBERNATE = 3'd4;

    localparam logic [1:0] KIND_TASK = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_REPLY = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       wake;
    } t_ent;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_ROTATE,
        CMD_REBASE
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic        force_head;
        t_ent        ent;
        logic [16:0] sum;
    } t_cell_ctrl;
endpackage
`default_nettype wire

@@ design/tts_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module tts_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [tts_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [7:0]               i_divisor,
    output logic                          o_done,
    output logic [tts_pkg::DIV_W-1:0]     o_quo,
    output logic [7:0]                    o_rem
);
    logic                          r_busy;
    logic [tts_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [tts_pkg::DIV_W-1:0]     r_quo;
    logic [7:0]                    r_rem;
    logic [7:0]                    r_div;
    logic                          r_done;
    logic [8:0]                    trial;
    logic [8:0]                    diff;

    assign trial = {r_rem, r_quo[tts_pkg::DIV_W-1]};
    assign diff = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
                r_quo <= i_dividend;
                r_rem <= '0;
                r_div <= i_divisor;
            end else if (r_busy) begin
                if (trial >= {1'b0, r_div}) begin
                    r_rem <= diff[7:0];
                    r_quo <= {r_quo[tts_pkg::DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial[7:0];
                    r_quo <= {r_quo[tts_pkg::DIV_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == tts_pkg::DIV_CNT_W'(tts_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo = r_quo;
    assign o_rem = r_rem;
endmodule
`default_nettype wire

@@ design/tts_cell.sv @@
// One queue position: holds a slot and its wake tick, shifts with its neighbors.
`default_nettype none
module tts_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tts_pkg::t_cell_ctrl i_ctrl,
    input  wire tts_pkg::t_ent       i_left,
    input  wire tts_pkg::t_ent       i_right,
    input  wire logic                i_found,
    output logic                     o_found,
    output tts_pkg::t_ent            o_ent
);
    tts_pkg::t_ent r_ent;
    tts_pkg::t_ent n_ent;
    logic          hit;

    always_comb begin
        hit = 1'b0;
        case (i_ctrl.cmd)
            tts_pkg::CMD_INSERT: hit = i_ctrl.force_head || !r_ent.valid
                                       || (r_ent.wake > i_ctrl.ent.wake);
            tts_pkg::CMD_REMOVE: hit = r_ent.valid && (r_ent.slot == i_ctrl.ent.slot);
            default:             hit = 1'b0;
        endcase
    end

    assign o_found = i_found | hit;

    always_comb begin
        n_ent = r_ent;
        case (i_ctrl.cmd)
            tts_pkg::CMD_INSERT: begin
                if (i_found) n_ent = i_left;
                else if (hit) n_ent = i_ctrl.ent;
            end
            tts_pkg::CMD_REMOVE: begin
                if (i_found || hit) n_ent = i_right;
            end
            tts_pkg::CMD_ROTATE: begin
                if (i_right.valid) n_ent = i_right;
                else if (r_ent.valid) n_ent = i_ctrl.ent;
            end
            tts_pkg::CMD_REBASE: begin
                if (r_ent.valid && r_ent.wake != tts_pkg::WAKE_NEVER) begin
                    if ({1'b0, r_ent.wake} > i_ctrl.sum) begin
                        n_ent.wake = r_ent.wake - i_ctrl.sum[15:0];
                    end else begin
                        n_ent.wake = '0;
                    end
                end
            end
            default: n_ent = r_ent;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent <= n_ent;
        end
    end

    assign o_ent = r_ent;
endmodule
`default_nettype wire

@@ design/timed_task_wakeup_scheduler_core.sv @@
// Top level of the timed task wakeup scheduler: control sequencer over a row of queue cells.
//
//  channel   direction  handshake             payload
//  s_axis    in         tvalid/tready         tuser op, tdata now_ms/task_slot/delay_ticks
//  m_axis    out        tvalid/tready/tlast   tuser kind, tdata slot_out/status/ticks_advanced
//  cfg       in         wr_en                 wr_data tick_period_ms
//
// Fork and kill reply from S_REPLY; queue and hibernate on a valid slot pass through S_INS first.
// A tick runs the 16-step divider, then S_TADJ, then S_DISP, which emits one result per dispatched task.
// Requests are taken only between operations; results wait in the output register.
// Reset is synchronous; the queue is empty after reset.
`default_nettype none
module timed_task_wakeup_scheduler_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,  // now_ms, task_slot, delay_ticks
    input  wire logic [2:0]  i_s_axis_tuser,  // op
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,  // slot_out, status, ticks_advanced, pad
    output logic [1:0]       o_m_axis_tuser,  // kind
    output logic             o_m_axis_tlast,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data
);
    localparam int SLOTS = tts_pkg::SLOTS;
    localparam int SLOT_W = tts_pkg::SLOT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_TADJ, S_DISP, S_INS, S_REPLY
    } t_state;

    t_state                     r_state;
    logic [SLOTS-1:0]           r_used;
    logic [15:0]                r_timer;
    logic [7:0]                 r_acc;
    logic [15:0]                r_last_ms;
    logic [7:0]                 r_period;
    logic [SLOT_W-1:0]          r_slot;
    logic [15:0]                r_w;
    logic [7:0]                 r_reply_slot;
    logic                       r_reply_st;
    logic [15:0]                r_d;
    logic [tts_pkg::GUARD_W-1:0] r_guard;
    logic                       r_ov;
    logic [1:0]                 r_okind;
    logic [7:0]                 r_oslot;
    logic                       r_ost;
    logic [15:0]                r_oadv;
    logic                       r_olast;

    logic [2:0]   in_op;
    logic [15:0]  in_now;
    logic [7:0]   in_slot;
    logic [15:0]  in_dt;
    logic         accept;
    logic         out_free;
    logic         ov_set;
    logic [7:0]   period_eff;
    logic         slot_ok;
    logic         free_found;
    logic [SLOT_W-1:0] free_slot;
    logic [16:0]  queue_sum;
    logic [15:0]  queue_w;
    logic         div_start;
    logic         div_done;
    logic [15:0]  div_quo;
    logic [7:0]   div_rem;
    logic [16:0]  d_inc;
    logic [16:0]  tick_sum;
    logic         head_due;

    tts_pkg::t_cell_ctrl ctrl;
    tts_pkg::t_ent       cell_ent [SLOTS];
    logic [SLOTS:0]      found_chain;
    logic [SLOTS-1:0]    cell_valid;

    assign in_now = i_s_axis_tdata[15:0];
    assign in_slot = i_s_axis_tdata[23:16];
    assign in_dt = i_s_axis_tdata[39:24];
    assign in_op = i_s_axis_tuser;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ov || i_m_axis_tready;
    assign ov_set = out_free && ((r_state == S_DISP) || (r_state == S_REPLY));
    assign period_eff = (r_period == 8'd0) ? 8'd1 : r_period;
    assign slot_ok = ({1'b0, in_slot} < 9'(SLOTS)) && r_used[in_slot[SLOT_W-1:0]];

    always_comb begin
        free_found = 1'b0;
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign queue_sum = {1'b0, r_timer} + {1'b0, (in_dt == 16'd0) ? 16'd1 : in_dt};
    assign queue_w = (queue_sum > {1'b0, tts_pkg::WAKE_SAT}) ? tts_pkg::WAKE_SAT
                                                              : queue_sum[15:0];
    assign d_inc = {1'b0, div_quo} + 17'd1;
    assign tick_sum = {1'b0, r_timer} + {1'b0, r_d};
    assign head_due = cell_ent[0].valid && (cell_ent[0].wake <= r_timer)
                      && (r_guard < tts_pkg::GUARD_W'(SLOTS));
    assign div_start = accept && (in_op == tts_pkg::OP_TICK);

    tts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (in_now - r_last_ms),
        .i_divisor  (period_eff),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_comb begin
        ctrl.cmd = tts_pkg::CMD_HOLD;
        ctrl.force_head = 1'b0;
        ctrl.ent = '{valid: 1'b1, slot: in_slot[SLOT_W-1:0], wake: r_timer};
        ctrl.sum = tick_sum;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_op == tts_pkg::OP_FORK && free_found) begin
                        ctrl.cmd = tts_pkg::CMD_INSERT;
                        ctrl.force_head = 1'b1;
                        ctrl.ent.slot = free_slot;
                    end else if ((in_op == tts_pkg::OP_KILL || in_op == tts_pkg::OP_QUEUE
                                  || in_op == tts_pkg::OP_HIBERNATE) && slot_ok) begin
                        ctrl.cmd = tts_pkg::CMD_REMOVE;
                    end
                end
            end
            S_TADJ: begin
                if (tick_sum > tts_pkg::REBASE_LIM) ctrl.cmd = tts_pkg::CMD_REBASE;
            end
            S_DISP: begin
                if (out_free && head_due) begin
                    ctrl.cmd = tts_pkg::CMD_ROTATE;
                    ctrl.ent.slot = cell_ent[0].slot;
                    ctrl.ent.wake = tts_pkg::WAKE_NEVER;
                end
            end
            S_INS: begin
                ctrl.cmd = tts_pkg::CMD_INSERT;
                ctrl.ent.slot = r_slot;
                ctrl.ent.wake = r_w;
            end
            default: ctrl.cmd = tts_pkg::CMD_HOLD;
        endcase
    end

    assign found_chain[0] = 1'b0;
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        tts_pkg::t_ent left_ent;
        tts_pkg::t_ent right_ent;
        if (g == 0) begin : g_first
            assign left_ent = '0;
        end else begin : g_mid
            assign left_ent = cell_ent[g-1];
        end
        if (g == SLOTS - 1) begin : g_last
            assign right_ent = '0;
        end else begin : g_inner
            assign right_ent = cell_ent[g+1];
        end
        tts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_left  (left_ent),
            .i_right (right_ent),
            .i_found (found_chain[g]),
            .o_found (found_chain[g+1]),
            .o_ent   (cell_ent[g])
        );
        assign cell_valid[g] = cell_ent[g].valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_timer <= '0;
            r_acc <= '0;
            r_last_ms <= '0;
            r_period <= 8'd1;
            r_ov <= 1'b0;
            r_guard <= '0;
        end else begin
            if (i_cfg_wr_en) r_period <= i_cfg_wr_data;
            r_ov <= ov_set || (r_ov && !i_m_axis_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_slot <= in_slot[SLOT_W-1:0];
                        r_w <= (in_op == tts_pkg::OP_QUEUE) ? queue_w : tts_pkg::WAKE_NEVER;
                        case (in_op)
                            tts_pkg::OP_TICK: begin
                                r_last_ms <= in_now;
                                r_state <= S_DIV;
                            end
                            tts_pkg::OP_FORK: begin
                                r_state <= S_REPLY;
                                r_reply_slot <= free_found ? 8'(free_slot)
                                                           : tts_pkg::SLOT_NONE;
                                r_reply_st <= !free_found;
                                if (free_found) r_used[free_slot] <= 1'b1;
                            end
                            tts_pkg::OP_KILL: begin
                                r_state <= S_REPLY;
                                r_reply_slot <= tts_pkg::SLOT_NONE;
                                r_reply_st <= !slot_ok;
                                if (slot_ok) r_used[in_slot[SLOT_W-1:0]] <= 1'b0;
                            end
                            tts_pkg::OP_QUEUE, tts_pkg::OP_HIBERNATE: begin
                                r_state <= slot_ok ? S_INS : S_REPLY;
                                r_reply_slot <= tts_pkg::SLOT_NONE;
                                r_reply_st <= !slot_ok;
                            end
                            default: begin
                                r_state <= S_REPLY;
                                r_reply_slot <= tts_pkg::SLOT_NONE;
                                r_reply_st <= 1'b1;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (div_rem >= r_acc) begin
                            r_acc <= r_acc + period_eff - div_rem;
                            r_d <= d_inc[16] ? 16'hFFFF : d_inc[15:0];
                        end else begin
                            r_acc <= r_acc - div_rem;
                            r_d <= div_quo;
                        end
                        r_state <= S_TADJ;
                    end
                end
                S_TADJ: begin
                    r_timer <= (tick_sum > tts_pkg::REBASE_LIM) ? 16'd0 : tick_sum[15:0];
                    r_guard <= '0;
                    r_state <= S_DISP;
                end
                S_DISP: begin
                    if (out_free) begin
                        r_oadv <= r_d;
                        r_ost <= 1'b0;
                        if (head_due) begin
                            r_okind <= tts_pkg::KIND_TASK;
                            r_oslot <= 8'(cell_ent[0].slot);
                            r_olast <= 1'b0;
                            r_guard <= r_guard + 1'b1;
                        end else begin
                            r_okind <= tts_pkg::KIND_DONE;
                            r_oslot <= tts_pkg::SLOT_NONE;
                            r_olast <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_INS: begin
                    r_state <= S_REPLY;
                end
                S_REPLY: begin
                    if (out_free) begin
                        r_okind <= tts_pkg::KIND_REPLY;
                        r_oslot <= r_reply_slot;
                        r_ost <= r_reply_st;
                        r_oadv <= '0;
                        r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata = {7'd0, r_oadv, r_ost, r_oslot};
    assign o_m_axis_tuser = r_okind;
    assign o_m_axis_tlast = r_olast;

    // queue length equals the used slot count, except while a slot is out for reinsertion
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INS) |-> ($countones(cell_valid) == $countones(r_used)))
        else $error("queue length differs from used slot count");

    // occupied cells are packed at the head
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cell_valid & (cell_valid + 1'b1)) == '0)
        else $error("gap in queue cells");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_okind == tts_pkg::KIND_DONE) |-> r_olast)
        else $error("tick done result without last");

    a_div_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside tick");
endmodule
`default_nettype wire
